### rtl/olkd_pkg.sv
package olkd_pkg;

  localparam int unsigned DEF_DEPTH = 16;
  localparam int unsigned VAL_W     = 32;

  // command codes on cmd_i
  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_DEL_FIRST = 3'd1,
    CMD_DEL_LAST  = 3'd2,
    CMD_DEL_KEY   = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  // status codes on status_o
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOKEY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_APPEND    = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_LAST  = 3'd3,
    OP_DEL_KEY   = 3'd4,
    OP_ROTATE    = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

### rtl/olkd_cell.sv
module olkd_cell
  import olkd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_DEPTH,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CW-1:0]    count_i,
  input  logic [VAL_W-1:0] next_i,
  input  logic [VAL_W-1:0] head_i,
  input  logic             hit_i,
  output logic             hit_o,
  output logic [VAL_W-1:0] val_o,
  output logic [VAL_W-1:0] tap_o
);

  localparam logic [CW-1:0] MyIdx  = CW'(IDX);
  localparam logic [CW-1:0] MyNext = CW'(IDX + 1);

  logic [VAL_W-1:0] val_q, val_d;
  logic             occ, is_tail, match;

  assign occ     = MyIdx < count_i;
  assign is_tail = MyNext == count_i;
  assign match   = occ && (val_q == ctrl_i.key);
  assign hit_o   = hit_i | match;
  assign val_o   = val_q;

  always_comb begin
    val_d = val_q;
    tap_o = '0;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (MyIdx == count_i) val_d = ctrl_i.key;
      end
      OP_DEL_FIRST: begin
        val_d = next_i;
        if (IDX == 0) tap_o = val_q;
      end
      OP_DEL_LAST: begin
        if (is_tail) tap_o = val_q;
      end
      OP_DEL_KEY: begin
        // first matching cell hands out its value, it and all later cells close up
        if (hit_o) val_d = next_i;
        if (match && !hit_i) tap_o = val_q;
      end
      OP_ROTATE: begin
        if (is_tail) val_d = head_i;
        else if (occ) val_d = next_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### rtl/ordered_list_with_key_delete.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------------
// command  | in        | start_i && !busy_o          | cmd_i, operand_value_i
// result   | out       | result_valid_o (one cycle)  | status_o, result_value_o, entry_count_o,
//          |           |                            | last_result_o
//
// a command is taken in one cycle, executed in the next, and its result shows in the
// cycle after that; the execute step of the cell row is registered
// a dump of n entries gives n results back to back (one rotation of the row per result)
// and holds busy_o through the walk; an empty dump gives one result
// the result port cannot be stalled; a new command may be taken while a result is shown
// reset clears the state machine, the entry count and the result strobe; entry values are
// not reset, cells above the count are never read
module ordered_list_with_key_delete
  import olkd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_DEPTH,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              cmd_i,
  input  logic signed [VAL_W-1:0] operand_value_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic [CW-1:0]           entry_count_o,
  output logic                    last_result_o
);

  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [CW-1:0] One  = CW'(1);

  // one-hot sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // latched command
  logic [2:0]       cmd_q;
  logic [VAL_W-1:0] key_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] dump_q, dump_d;

  // result register
  logic             rvalid_q, rvalid_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] rval_q, rval_d;
  logic             rlast_q, rlast_d;

  // cell row
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [VAL_W-1:0] cell_tap [DEPTH];
  logic [DEPTH:0]   hit;
  logic [VAL_W-1:0] tap_or;
  logic             is_empty, is_full, key_found;

  assign is_empty  = count_q == '0;
  assign is_full   = count_q == Full;
  assign key_found = hit[DEPTH];
  assign hit[0]    = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] next_val;
    // last cell has no right neighbor, it is never occupied after a shift anyway
    if (g == DEPTH - 1) begin : g_end
      assign next_val = cell_val[g];
    end else begin : g_mid
      assign next_val = cell_val[g+1];
    end

    olkd_cell #(
      .DEPTH(DEPTH),
      .IDX  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .next_i (next_val),
      .head_i (cell_val[0]),
      .hit_i  (hit[g]),
      .hit_o  (hit[g+1]),
      .val_o  (cell_val[g]),
      .tap_o  (cell_tap[g])
    );
  end

  // at most one cell drives a non-zero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // operation handed to the row
  always_comb begin
    ctrl.key = key_q;
    ctrl.op  = OP_HOLD;
    if (state_q == S_EXEC) begin
      case (cmd_q)
        CMD_APPEND:    if (!is_full) ctrl.op = OP_APPEND;
        CMD_DEL_FIRST: if (!is_empty) ctrl.op = OP_DEL_FIRST;
        CMD_DEL_LAST:  if (!is_empty) ctrl.op = OP_DEL_LAST;
        CMD_DEL_KEY:   if (!is_empty) ctrl.op = OP_DEL_KEY;
        default:       ctrl.op = OP_HOLD;
      endcase
    end else if (state_q == S_DUMP) begin
      ctrl.op = OP_ROTATE;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    dump_d   = dump_q;
    rvalid_d = 1'b0;
    status_d = status_q;
    rval_d   = rval_q;
    rlast_d  = rlast_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d  = S_IDLE;
        rvalid_d = 1'b1;
        status_d = ST_OK;
        rval_d   = '0;
        rlast_d  = 1'b1;
        case (cmd_q)
          CMD_APPEND: begin
            if (is_full) status_d = ST_FULL;
            else count_d = count_q + One;
          end
          CMD_DEL_FIRST, CMD_DEL_LAST: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
            end else begin
              rval_d  = tap_or;
              count_d = count_q - One;
            end
          end
          CMD_DEL_KEY: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
            end else if (key_found) begin
              rval_d  = tap_or;
              count_d = count_q - One;
            end else begin
              status_d = ST_NOKEY;
            end
          end
          CMD_DUMP: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
            end else begin
              // results come from the dump walk
              rvalid_d = 1'b0;
              dump_d   = '0;
              state_d  = S_DUMP;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_DUMP: begin
        // head of the row is out, the row rotates by one
        rvalid_d = 1'b1;
        status_d = ST_OK;
        rval_d   = cell_val[0];
        rlast_d  = (dump_q + One) == count_q;
        dump_d   = dump_q + One;
        if (rlast_d) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q <= cmd_i;
      key_q <= operand_value_i;
    end
    dump_q   <= dump_d;
    status_q <= status_d;
    rval_q   <= rval_d;
    rlast_q  <= rlast_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign result_value_o = rval_q;
  assign entry_count_o  = count_q;
  assign last_result_o  = rlast_q;

endmodule

### rtl/olkd_checker.sv
module olkd_checker
  import olkd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_DEPTH,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic [2:0]              cmd_i,
  input logic signed [VAL_W-1:0] operand_value_i,
  input logic                    result_valid_o,
  input logic [1:0]              status_o,
  input logic signed [VAL_W-1:0] result_value_o,
  input logic [CW-1:0]           entry_count_o,
  input logic                    last_result_o
);

  localparam logic [CW-1:0] Full = CW'(DEPTH);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("no busy after a command was taken");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |=> !result_valid_o)
    else $error("result right after the last result of a command");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> entry_count_o <= Full)
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_FULL |-> entry_count_o == Full)
    else $error("full status with room left");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> result_value_o == '0)
    else $error("non-zero value on a failed command");

endmodule

bind ordered_list_with_key_delete olkd_checker #(.DEPTH(DEPTH)) u_olkd_checker (.*);

### test/ordered_list_with_key_delete_tb.sv
module ordered_list_with_key_delete_tb;
  import olkd_pkg::*;

  localparam int unsigned DEPTH = DEF_DEPTH;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // command codes the block ignores (one plain ok result each)
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned RANDOM_ITEMS = 310;
  // a full dump is the longest burst of results, so drain for a couple of those
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  // worst item: the longest idle gap plus a full dump, ~350 items
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // one result as the block should show it
  typedef struct {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
    logic [CW-1:0]           count;
    logic                    last;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [2:0]              cmd;
  logic signed [VAL_W-1:0] operand;
  logic                    res_valid;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] res_value;
  logic [CW-1:0]           count;
  logic                    last;

  // our own copy of the list, head at index 0
  logic signed [VAL_W-1:0] list_model[$];
  // results still owed by the block, oldest first
  list_result_t            pending_results[$];

  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  // when set, the sender issues items back to back
  bit          burst_mode = 1'b0;

  ordered_list_with_key_delete dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .cmd_i           (cmd),
    .operand_value_i (operand),
    .result_valid_o  (res_valid),
    .status_o        (status),
    .result_value_o  (res_value),
    .entry_count_o   (count),
    .last_result_o   (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs or stays busy
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ordered_list_with_key_delete_tb NOT OK");
      $finish;
    end
  end

  // work out the results of one accepted item and update the list copy
  function automatic void predict_list_op(input logic [2:0] op_cmd,
                                          input logic signed [VAL_W-1:0] op_value);
    list_result_t r;
    int           hit;
    r.status = ST_OK;
    r.value  = '0;
    r.last   = 1'b1;
    hit      = -1;
    case (op_cmd)
      CMD_APPEND: begin
        // a full list drops the value
        if (list_model.size() >= DEPTH) r.status = ST_FULL;
        else list_model.push_back(op_value);
      end
      CMD_DEL_FIRST: begin
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else r.value = list_model.pop_front();
      end
      CMD_DEL_LAST: begin
        // a single entry leaves the list empty
        if (list_model.size() == 0) r.status = ST_EMPTY;
        else r.value = list_model.pop_back();
      end
      CMD_DEL_KEY: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // earliest match wins
          for (int i = 0; i < list_model.size() && hit < 0; i++)
            if (list_model[i] == op_value) hit = i;
          if (hit < 0) begin
            r.status = ST_NOKEY;
          end else begin
            r.value = list_model[hit];
            list_model.delete(hit);
          end
        end
      end
      CMD_DUMP: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // one result per entry, head to tail, last flag on the tail
          for (int i = 0; i < list_model.size(); i++) begin
            r.value = list_model[i];
            r.count = CW'(list_model.size());
            r.last  = (i == list_model.size() - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ; // spare codes: plain ok, list untouched
    endcase
    r.count = CW'(list_model.size());
    pending_results.push_back(r);
  endfunction

  // hand one item to the block after a random idle gap (none in burst mode); start stays high after
  // acceptance so that a back-to-back item does not toggle it within one step
  task automatic send_list_op(input logic [2:0] op_cmd,
                              input logic signed [VAL_W-1:0] op_value);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= op_cmd;
    operand <= op_value;
    do @(posedge clk); while (busy);
    predict_list_op(op_cmd, op_value);
  endtask

  // full-range values, a small pool that makes duplicate keys, and the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed(VAL_W'($urandom_range(0, 7))) - 4;
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [VAL_W-1:0] exp_val,
                               input logic [VAL_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // every strobed result is checked against the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n === 1'b1 && res_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d value %0h count %0d",
               status, res_value, count);
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("status", VAL_W'(exp_r.status), VAL_W'(status));
        compare_field("result_value", exp_r.value, res_value);
        compare_field("entry_count", VAL_W'(exp_r.count), VAL_W'(count));
        compare_field("last_result", VAL_W'(exp_r.last), VAL_W'(last));
      end
    end
  end

  // every delete and the dump on an empty list, plus a spare code
  task automatic test_empty_list();
    send_list_op(CMD_DEL_FIRST, pick_value());
    send_list_op(CMD_DEL_LAST, pick_value());
    send_list_op(CMD_DEL_KEY, pick_value());
    send_list_op(CMD_DUMP, pick_value());
    send_list_op(CMD_SPARE_LO, pick_value());
  endtask

  // extreme values, ordering after removals, key miss, spare codes,
  // and delete-last on a single entry
  task automatic test_extremes_and_order();
    send_list_op(CMD_APPEND, 32'sh7fff_ffff);
    send_list_op(CMD_APPEND, 32'sh8000_0000);
    send_list_op(CMD_APPEND, '0);
    send_list_op(CMD_APPEND, -1);
    send_list_op(CMD_APPEND, 1);
    send_list_op(CMD_DUMP, '0);
    // key from the middle of the list
    send_list_op(CMD_DEL_KEY, -1);
    // key not held
    send_list_op(CMD_DEL_KEY, 32'sh1234_5678);
    send_list_op(CMD_SPARE_MID, 32'sh5555_5555);
    send_list_op(CMD_SPARE_HI, 32'shaaaa_aaaa);
    send_list_op(CMD_DEL_FIRST, '0);
    send_list_op(CMD_DEL_LAST, '0);
    send_list_op(CMD_DUMP, '0);
    send_list_op(CMD_DEL_LAST, '0);
    // single entry left: delete-last empties the list
    send_list_op(CMD_DEL_LAST, '0);
    send_list_op(CMD_DUMP, '0);
  endtask

  // fill to the top, overflow, full dump, earliest-match removal, refill
  task automatic test_full_list();
    burst_mode = 1'b1;
    repeat (DEPTH / 2) send_list_op(CMD_APPEND, pick_value());
    burst_mode = 1'b0;
    while (list_model.size() < DEPTH) send_list_op(CMD_APPEND, pick_value());
    send_list_op(CMD_APPEND, pick_value());
    send_list_op(CMD_DUMP, pick_value());
    send_list_op(CMD_DEL_KEY, list_model[DEPTH-1]);
    send_list_op(CMD_APPEND, pick_value());
    send_list_op(CMD_APPEND, pick_value());
  endtask

  // random mix in segments, each with its own append bias and idle style
  task automatic test_random_mix();
    int unsigned             append_bias;
    int unsigned             pick;
    logic [2:0]              op;
    logic signed [VAL_W-1:0] v;
    append_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        append_bias = $urandom_range(25, 70);
        burst_mode  = ($urandom_range(0, 3) == 0);
      end
      v = pick_value();
      if ($urandom_range(0, 99) < append_bias) begin
        op = CMD_APPEND;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          op = CMD_DEL_FIRST;
        end else if (pick < 50) begin
          op = CMD_DEL_LAST;
        end else if (pick < 80) begin
          op = CMD_DEL_KEY;
          // mostly a key that is held, so removals land anywhere in the list
          if (list_model.size() != 0 && $urandom_range(0, 9) < 7)
            v = list_model[$urandom_range(0, list_model.size() - 1)];
        end else if (pick < 96) begin
          op = CMD_DUMP;
        end else begin
          op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
      end
      send_list_op(op, v);
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    cmd     <= CMD_APPEND;
    operand <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_extremes_and_order();
    test_full_list();
    test_random_mix();

    // same step as the last acceptance, so start gets one assignment here
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("ordered_list_with_key_delete_tb OK");
    end else begin
      $display("ordered_list_with_key_delete_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/olkd_pkg.sv
rtl/olkd_cell.sv
rtl/ordered_list_with_key_delete.sv
rtl/olkd_checker.sv
test/ordered_list_with_key_delete_tb.sv
